// ===== sv/cs2x2_pkg.sv =====
// Shared widths and pipeline types for the 2x2 Cramer solver.
`timescale 1ns / 1ps

package cs2x2_pkg;

  // Data format of every field: signed fixed point.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int EPS_WIDTH  = 31;

  // Derived widths.
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int REM_W   = MAG_W + 1;
  localparam int SHIFT_W = DATA_WIDTH - FRAC_BITS;

  // Stage counts of the pipeline: front end, divider and output register.
  localparam int FRONT_STAGES = 4;
  localparam int DIV_STAGES   = DATA_WIDTH;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

  // Payload that travels down the divider pipeline, two lanes side by side.
  typedef struct packed {
    logic                              sing;
    logic [1:0]                        neg;
    logic [1:0]                        ovf;
    logic [MAG_W-1:0]                  den;
    logic [1:0][REM_W-1:0]             rem;
    logic [1:0][DATA_WIDTH-1:0]        low;
    logic [1:0][DATA_WIDTH-1:0]        quo;
  } div_pipe_t;

endpackage

// ===== sv/cs2x2_front.sv =====
// Front end: products, cross differences, magnitudes and the singular test.
`timescale 1ns / 1ps

module cs2x2_front import cs2x2_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic signed [DATA_WIDTH-1:0] a00,
  input  logic signed [DATA_WIDTH-1:0] a01,
  input  logic signed [DATA_WIDTH-1:0] a10,
  input  logic signed [DATA_WIDTH-1:0] a11,
  input  logic signed [DATA_WIDTH-1:0] rhs0,
  input  logic signed [DATA_WIDTH-1:0] rhs1,
  input  logic [EPS_WIDTH-1:0]         eps,
  output logic                         out_vld,
  output div_pipe_t                    out_pipe
);

  logic v1, v2, v3;
  logic signed [PROD_W-1:0]  p_a00a11, p_a01a10, p_r0a11, p_a01r1, p_a00r1, p_r0a10;
  logic signed [CROSS_W-1:0] det_x, num0_x, num1_x;
  logic [MAG_W-1:0]          det_mag;
  logic [1:0][MAG_W-1:0]     num_mag;
  logic                      det_neg;
  logic [1:0]                num_neg;
  logic [MAG_W-1:0]          thr;
  logic [1:0][MAG_W-1:0]     hi_part;
  div_pipe_t                 pipe_next;

  // Valid bits follow the items through the four front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      out_vld <= v3;
    end
  end

  // Stage one: six full-width products.
  always_ff @(posedge clk) begin
    p_a00a11 <= a00 * a11;
    p_a01a10 <= a01 * a10;
    p_r0a11  <= rhs0 * a11;
    p_a01r1  <= a01 * rhs1;
    p_a00r1  <= a00 * rhs1;
    p_r0a10  <= rhs0 * a10;
  end

  // Stage two: exact determinants, one bit wider than a product.
  always_ff @(posedge clk) begin
    det_x  <= CROSS_W'(p_a00a11) - CROSS_W'(p_a01a10);
    num0_x <= CROSS_W'(p_r0a11) - CROSS_W'(p_a01r1);
    num1_x <= CROSS_W'(p_a00r1) - CROSS_W'(p_r0a10);
  end

  // Stage three: split into sign and magnitude.
  always_ff @(posedge clk) begin
    det_neg    <= det_x[CROSS_W-1];
    num_neg[0] <= num0_x[CROSS_W-1];
    num_neg[1] <= num1_x[CROSS_W-1];
    det_mag    <= det_x[CROSS_W-1] ? MAG_W'(-det_x) : MAG_W'(det_x);
    num_mag[0] <= num0_x[CROSS_W-1] ? MAG_W'(-num0_x) : MAG_W'(num0_x);
    num_mag[1] <= num1_x[CROSS_W-1] ? MAG_W'(-num1_x) : MAG_W'(num1_x);
  end

  // Stage four: singular test, quotient overflow test and divider setup.
  // The scaled numerator splits into a high part, which must stay below the
  // divisor for the quotient to fit, and a low word shifted in bit by bit.
  always_comb begin
    thr = MAG_W'(eps) << FRAC_BITS;
    pipe_next.sing = (det_mag == '0) || (det_mag < thr);
    pipe_next.den  = det_mag;
    for (int i = 0; i < 2; i++) begin
      hi_part[i]         = num_mag[i] >> SHIFT_W;
      pipe_next.neg[i]   = (num_neg[i] != det_neg) && (num_mag[i] != '0);
      pipe_next.ovf[i]   = hi_part[i] >= det_mag;
      pipe_next.rem[i]   = REM_W'(hi_part[i]);
      pipe_next.low[i]   = DATA_WIDTH'(num_mag[i][SHIFT_W-1:0]) << FRAC_BITS;
      pipe_next.quo[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    out_pipe <= pipe_next;
  end

endmodule

// ===== sv/cs2x2_div_step.sv =====
// One registered step of the restoring divider, both quotient lanes.
`timescale 1ns / 1ps

module cs2x2_div_step import cs2x2_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_vld,
  input  div_pipe_t in_pipe,
  output logic      out_vld,
  output div_pipe_t out_pipe
);

  logic [1:0][REM_W-1:0] shifted;
  logic [REM_W-1:0]      den_ext;
  logic [1:0]            qbit;
  div_pipe_t             pipe_next;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    pipe_next = in_pipe;
    den_ext   = REM_W'(in_pipe.den);
    for (int i = 0; i < 2; i++) begin
      shifted[i] = {in_pipe.rem[i][REM_W-2:0], in_pipe.low[i][DATA_WIDTH-1]};
      qbit[i]    = shifted[i] >= den_ext;
      pipe_next.rem[i] = qbit[i] ? (shifted[i] - den_ext) : shifted[i];
      pipe_next.low[i] = in_pipe.low[i] << 1;
      pipe_next.quo[i] = {in_pipe.quo[i][DATA_WIDTH-2:0], qbit[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_pipe <= pipe_next;
  end

endmodule

// ===== sv/cramer_solve_2x2_unit.sv =====
// Top level of the pipelined 2x2 Cramer's rule solver.
`timescale 1ns / 1ps

// Solves a 2x2 system A x = b given in signed Q16.16 and returns x in Q16.16.
// The block accepts one item in every cycle (busy is high only during reset),
// and each item passes four front stages (products, exact determinants,
// magnitudes, singular test), then one stage per quotient bit of the
// restoring divider, then the saturation register before its result
// appears on done. Results cannot be held off. A determinant whose magnitude
// is below singular_eps gives zeros and singular; a quotient outside the
// 32-bit signed range is clamped and flags saturated. Quotients are
// truncated toward zero. Write the epsilon only while no item is in flight.

module cramer_solve_2x2_unit import cs2x2_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] a00,
  input  logic signed [DATA_WIDTH-1:0] a01,
  input  logic signed [DATA_WIDTH-1:0] a10,
  input  logic signed [DATA_WIDTH-1:0] a11,
  input  logic signed [DATA_WIDTH-1:0] rhs0,
  input  logic signed [DATA_WIDTH-1:0] rhs1,
  input  logic                         eps_we,
  input  logic [EPS_WIDTH-1:0]         eps_wdata,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] sol0,
  output logic signed [DATA_WIDTH-1:0] sol1,
  output logic                         singular,
  output logic                         saturated
);

  logic [EPS_WIDTH-1:0]       singular_eps;
  logic                       accept;
  logic [DIV_STAGES:0]        vld;
  div_pipe_t                  pipe [DIV_STAGES+1];
  logic [1:0]                 sat;
  logic [1:0][DATA_WIDTH-1:0] res;
  logic [DATA_WIDTH-1:0]      qmax;
  div_pipe_t                  last;

  assign busy   = rst;
  assign accept = start && !busy;

  // Epsilon register.
  always_ff @(posedge clk) begin
    if (rst) begin
      singular_eps <= EPS_WIDTH'(1);
    end else if (eps_we) begin
      singular_eps <= eps_wdata;
    end
  end

  cs2x2_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .a00      (a00),
    .a01      (a01),
    .a10      (a10),
    .a11      (a11),
    .rhs0     (rhs0),
    .rhs1     (rhs1),
    .eps      (singular_eps),
    .out_vld  (vld[0]),
    .out_pipe (pipe[0])
  );

  // One divider stage per quotient bit.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    cs2x2_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (vld[s]),
      .in_pipe  (pipe[s]),
      .out_vld  (vld[s+1]),
      .out_pipe (pipe[s+1])
    );
  end

  // Clamp out-of-range quotients and apply the result sign.
  always_comb begin
    last = pipe[DIV_STAGES];
    for (int i = 0; i < 2; i++) begin
      qmax   = last.neg[i] ? (DATA_WIDTH'(1) << (DATA_WIDTH - 1))
                           : ((DATA_WIDTH'(1) << (DATA_WIDTH - 1)) - DATA_WIDTH'(1));
      sat[i] = last.ovf[i] || (last.quo[i] > qmax);
      if (last.sing) begin
        res[i] = '0;
      end else if (sat[i]) begin
        res[i] = last.neg[i] ? (DATA_WIDTH'(1) << (DATA_WIDTH - 1))
                             : ((DATA_WIDTH'(1) << (DATA_WIDTH - 1)) - DATA_WIDTH'(1));
      end else begin
        res[i] = last.neg[i] ? (-last.quo[i]) : last.quo[i];
      end
    end
  end

  // Output register: control part.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[DIV_STAGES];
    end
  end

  // Output register: result fields.
  always_ff @(posedge clk) begin
    sol0      <= res[0];
    sol1      <= res[1];
    singular  <= last.sing;
    saturated <= !last.sing && (sat[0] || sat[1]);
  end

`ifndef SYNTHESIS
  // Every accepted item yields a result on done, checked against LATENCY.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("item did not complete after the pipeline latency");

  // A result never appears without a matching accepted item, checked against LATENCY.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching item");

  // A singular result carries zero solutions and no saturation.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (sol0 == '0 && sol1 == '0 && !saturated))
    else $error("singular result with nonzero fields");
`endif

endmodule
